>>> hw/rtl/rif_pkg.sv
// Package: shared widths, configuration indexes and pipeline sideband type.
`timescale 1ns / 1ps
`default_nettype none
package rif_pkg;
  localparam int CW  = 24;
  localparam int DW  = 25;
  localparam int SQW = 48;
  localparam int NCELL = 24;

  typedef enum logic [2:0] {
    CFG_STRENGTH = 3'd0,
    CFG_MIN      = 3'd1,
    CFG_MAX      = 3'd2,
    CFG_CX       = 3'd3,
    CFG_CY       = 3'd4,
    CFG_CZ       = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic          in_range;
    logic          full;
    logic [2:0]    neg;
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] az;
    logic [CW-1:0] d;
    logic [CW-1:0] m;
  } side_t;
endpackage
`default_nettype wire

>>> hw/rtl/rif_sqrt_cell.sv
// Square root cell: one root bit per cell, radicand shifted two bits on.
`timescale 1ns / 1ps
`default_nettype none
module rif_sqrt_cell (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [25:0]           rem_i,
  input  wire logic [rif_pkg::CW-1:0]  root_i,
  input  wire logic [rif_pkg::SQW-1:0] rad_i,
  output logic      [25:0]           rem_o,
  output logic      [rif_pkg::CW-1:0]  root_o,
  output logic      [rif_pkg::SQW-1:0] rad_o
);
  import rif_pkg::*;

  logic [27:0]   r2;
  logic [27:0]   trial;
  logic [27:0]   diff;
  logic          ge;
  logic [25:0]   rem_nxt;
  logic [CW-1:0] root_nxt;

  always_comb begin
    r2       = {rem_i, rad_i[SQW-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    ge       = (r2 >= trial);
    diff     = r2 - trial;
    rem_nxt  = ge ? diff[25:0] : r2[25:0];
    root_nxt = {root_i[CW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
      rad_o  <= {rad_i[SQW-3:0], 2'b00};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/rif_div_cell.sv
// Restoring divide cell: one quotient bit per cell, 48 by 24 bits.
`timescale 1ns / 1ps
`default_nettype none
module rif_div_cell (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [rif_pkg::SQW-1:0] acc_i,
  input  wire logic [rif_pkg::CW-1:0]  dv_i,
  output logic      [rif_pkg::SQW-1:0] acc_o,
  output logic      [rif_pkg::CW-1:0]  dv_o
);
  import rif_pkg::*;

  logic [SQW:0]  t;
  logic [CW:0]   top;
  logic          ge;
  logic [CW:0]   top_sub;
  logic [SQW-1:0] acc_nxt;

  always_comb begin
    t       = {acc_i, 1'b0};
    top     = t[SQW -: CW+1];
    ge      = (top >= {1'b0, dv_i});
    top_sub = top - {1'b0, dv_i};
    acc_nxt = {(ge ? top_sub[CW-1:0] : top[CW-1:0]), t[CW-1:1], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_o <= acc_nxt;
      dv_o  <= dv_i;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/radial_impulse_falloff.sv
// Top level: pipelined explosion impulse with linear falloff.
//   channel | direction | ports
//   in      | in        | in_valid, in_ready, in_body_x/y/z
//   out     | out       | out_valid, out_ready, out_in_range, out_push_x/y/z
//   cfg     | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
// One item per cycle unless the output stalls; the pipeline holds three front stages, 24 square root
// cells, one multiply stage, 24 falloff divide cells, one multiply stage,
// 24 component divide cells and the output register.
// Reset clears valid bits and loads register defaults; cfg_ready is always high.
// A stall at the output holds the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none
module radial_impulse_falloff (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [rif_pkg::CW-1:0] in_body_x,
  input  wire logic [rif_pkg::CW-1:0] in_body_y,
  input  wire logic [rif_pkg::CW-1:0] in_body_z,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_in_range,
  output logic      [rif_pkg::DW-1:0] out_push_x,
  output logic      [rif_pkg::DW-1:0] out_push_y,
  output logic      [rif_pkg::DW-1:0] out_push_z,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [rif_pkg::CW-1:0] cfg_data
);
  import rif_pkg::*;

  localparam int NST = 3 * NCELL + 5;

  logic [CW-1:0] strength_r, fmin_r, fmax_r, cx_r, cy_r, cz_r;
  logic [SQW-1:0] max_sq_r, min_sq_r;
  logic [CW-1:0] span_r;

  logic adv;
  logic [NST-1:0] vld_r;

  logic [DW-1:0] dx_r, dy_r, dz_r;
  logic [DW-1:0] ax_w, ay_w, az_w;
  logic [2*DW-1:0] sqx_r, sqy_r, sqz_r;
  side_t side_b_r, side_c_r, side_d_r, side_e_r;
  side_t side_b_nxt, side_c_nxt, side_d_nxt, side_e_nxt;
  logic [2*DW:0] sq_w;
  logic [SQW-1:0] sq_r;

  side_t side_s_r [0:NCELL-1];
  side_t side_m_r [0:NCELL-1];
  side_t side_p_r [0:NCELL-1];

  logic [25:0]    srem [0:NCELL];
  logic [CW-1:0]  sroot [0:NCELL];
  logic [SQW-1:0] srad [0:NCELL];

  logic [SQW-1:0] macc [0:NCELL];
  logic [CW-1:0]  mdv [0:NCELL];
  logic [SQW-1:0] prod_r;

  logic [SQW-1:0] pxacc [0:NCELL];
  logic [SQW-1:0] pyacc [0:NCELL];
  logic [SQW-1:0] pzacc [0:NCELL];
  logic [CW-1:0]  pxdv [0:NCELL];
  logic [CW-1:0]  pydv [0:NCELL];
  logic [CW-1:0]  pzdv [0:NCELL];
  logic [SQW-1:0] mx_r, my_r, mz_r;
  logic [CW-1:0]  m_w;
  logic [CW-1:0]  span_sub;

  logic           out_vld_r;
  logic           out_rng_r;
  logic [DW-1:0]  push_x_r, push_y_r, push_z_r;
  side_t          side_last;

  assign cfg_ready = 1'b1;
  assign adv       = !out_vld_r || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= 24'd1280000;
      fmin_r     <= 24'd2560;
      fmax_r     <= 24'd25600;
      cx_r       <= '0;
      cy_r       <= '0;
      cz_r       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STRENGTH: strength_r <= cfg_data;
        CFG_MIN:      fmin_r     <= cfg_data;
        CFG_MAX:      fmax_r     <= cfg_data;
        CFG_CX:       cx_r       <= cfg_data;
        CFG_CY:       cy_r       <= cfg_data;
        CFG_CZ:       cz_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    max_sq_r <= fmax_r * fmax_r;
    min_sq_r <= fmin_r * fmin_r;
    span_r   <= fmax_r - fmin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  assign ax_w = dx_r[DW-1] ? (~dx_r + 1'b1) : dx_r;
  assign ay_w = dy_r[DW-1] ? (~dy_r + 1'b1) : dy_r;
  assign az_w = dz_r[DW-1] ? (~dz_r + 1'b1) : dz_r;
  assign sq_w = {1'b0, sqx_r} + {1'b0, sqy_r} + {1'b0, sqz_r};

  always_comb begin
    side_b_nxt          = '0;
    side_b_nxt.neg      = {dx_r[DW-1], dy_r[DW-1], dz_r[DW-1]};
    side_b_nxt.ax       = ax_w[CW-1:0];
    side_b_nxt.ay       = ay_w[CW-1:0];
    side_b_nxt.az       = az_w[CW-1:0];

    side_c_nxt          = side_b_r;
    side_c_nxt.in_range = (sq_w <= {3'b000, max_sq_r});
    side_c_nxt.full     = (sq_w <= {3'b000, min_sq_r});

    side_d_nxt          = side_s_r[NCELL-1];
    side_d_nxt.d        = sroot[NCELL];

    side_e_nxt          = side_m_r[NCELL-1];
    side_e_nxt.m        = m_w;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r <= {in_body_x[CW-1], in_body_x} - {cx_r[CW-1], cx_r};
      dy_r <= {in_body_y[CW-1], in_body_y} - {cy_r[CW-1], cy_r};
      dz_r <= {in_body_z[CW-1], in_body_z} - {cz_r[CW-1], cz_r};

      sqx_r    <= ax_w * ax_w;
      sqy_r    <= ay_w * ay_w;
      sqz_r    <= az_w * az_w;
      side_b_r <= side_b_nxt;

      sq_r     <= sq_w[SQW-1:0];
      side_c_r <= side_c_nxt;

      side_s_r[0] <= side_c_r;
      side_m_r[0] <= side_d_r;
      side_p_r[0] <= side_e_r;
      for (int k = 1; k < NCELL; k++) begin
        side_s_r[k] <= side_s_r[k-1];
        side_m_r[k] <= side_m_r[k-1];
        side_p_r[k] <= side_p_r[k-1];
      end

      side_d_r <= side_d_nxt;
      prod_r   <= strength_r * span_sub;

      side_e_r <= side_e_nxt;
      mx_r     <= m_w * side_m_r[NCELL-1].ax;
      my_r     <= m_w * side_m_r[NCELL-1].ay;
      mz_r     <= m_w * side_m_r[NCELL-1].az;
    end
  end

  assign span_sub = fmax_r - sroot[NCELL];
  assign m_w = side_m_r[NCELL-1].full ? strength_r : macc[NCELL][CW-1:0];

  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = sq_r;
  assign macc[0]  = prod_r;
  assign mdv[0]   = span_r;
  assign pxacc[0] = mx_r;
  assign pyacc[0] = my_r;
  assign pzacc[0] = mz_r;
  assign pxdv[0]  = side_e_r.d;
  assign pydv[0]  = side_e_r.d;
  assign pzdv[0]  = side_e_r.d;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    rif_sqrt_cell u_sqrt (
      .clk(clk), .en(adv),
      .rem_i(srem[k]), .root_i(sroot[k]), .rad_i(srad[k]),
      .rem_o(srem[k+1]), .root_o(sroot[k+1]), .rad_o(srad[k+1])
    );
    rif_div_cell u_mdiv (
      .clk(clk), .en(adv), .acc_i(macc[k]), .dv_i(mdv[k]),
      .acc_o(macc[k+1]), .dv_o(mdv[k+1])
    );
    rif_div_cell u_pxdiv (
      .clk(clk), .en(adv), .acc_i(pxacc[k]), .dv_i(pxdv[k]),
      .acc_o(pxacc[k+1]), .dv_o(pxdv[k+1])
    );
    rif_div_cell u_pydiv (
      .clk(clk), .en(adv), .acc_i(pyacc[k]), .dv_i(pydv[k]),
      .acc_o(pyacc[k+1]), .dv_o(pydv[k+1])
    );
    rif_div_cell u_pzdiv (
      .clk(clk), .en(adv), .acc_i(pzacc[k]), .dv_i(pzdv[k]),
      .acc_o(pzacc[k+1]), .dv_o(pzdv[k+1])
    );
  end

  assign side_last = side_p_r[NCELL-1];

  function automatic logic [DW-1:0] push_val(input logic ok, input logic neg,
                                             input logic [CW-1:0] mag);
    logic [DW-1:0] v;
    v = ok ? {1'b0, mag} : '0;
    return neg ? (~v + 1'b1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rng_r <= side_last.in_range;
      push_x_r  <= push_val(side_last.in_range && (side_last.d != '0),
                            side_last.neg[2], pxacc[NCELL][CW-1:0]);
      push_y_r  <= push_val(side_last.in_range && (side_last.d != '0),
                            side_last.neg[1], pyacc[NCELL][CW-1:0]);
      push_z_r  <= push_val(side_last.in_range && (side_last.d != '0),
                            side_last.neg[0], pzacc[NCELL][CW-1:0]);
    end
  end

  assign out_valid    = out_vld_r;
  assign out_in_range = out_rng_r;
  assign out_push_x   = push_x_r;
  assign out_push_y   = push_y_r;
  assign out_push_z   = push_z_r;
endmodule
`default_nettype wire

>>> hw/rtl/rif_checker.sv
// Checker: port-level assertions for the impulse pipeline, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rif_checker (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic [rif_pkg::CW-1:0] in_body_x,
  input wire logic [rif_pkg::CW-1:0] in_body_y,
  input wire logic [rif_pkg::CW-1:0] in_body_z,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic                   out_in_range,
  input wire logic [rif_pkg::DW-1:0] out_push_x,
  input wire logic [rif_pkg::DW-1:0] out_push_y,
  input wire logic [rif_pkg::DW-1:0] out_push_z
);
  import rif_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_body_x)
      && $stable(in_body_y) && $stable(in_body_z))
    else $error("waiting input item changed");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_push_x)
      && $stable(out_push_y) && $stable(out_push_z) && $stable(out_in_range))
    else $error("stalled item changed");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_push_x == '0 && out_push_y == '0
      && out_push_z == '0)
    else $error("out of range item has nonzero push");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind radial_impulse_falloff rif_checker u_rif_checker (.*);
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for radial_impulse_falloff: directed table, random bodies, scoreboard check.
`timescale 1ns / 1ps
module tb_top;
  import rif_pkg::*;

  typedef struct packed {
    logic          in_range;
    logic [DW-1:0] px;
    logic [DW-1:0] py;
    logic [DW-1:0] pz;
  } impulse_t;

  typedef struct {
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    logic [CW-1:0] bz;
    bit            typed;
    impulse_t      want;
  } row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [CW-1:0] in_body_x = '0;
  logic [CW-1:0] in_body_y = '0;
  logic [CW-1:0] in_body_z = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          out_in_range;
  logic [DW-1:0] out_push_x;
  logic [DW-1:0] out_push_y;
  logic [DW-1:0] out_push_z;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  cfg_idx_t      cfg_index = CFG_STRENGTH;
  logic [CW-1:0] cfg_data = '0;

  radial_impulse_falloff dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("** radial_impulse_falloff: FAILED **");
    $finish;
  end

  longint unsigned strength, fmin, fmax;
  longint          cen_x, cen_y, cen_z;
  impulse_t        pending_impulses[$];
  int              errors = 0;
  int              send_idle = 0;
  int              recv_idle = 0;
  bit              hold_req = 1'b0;
  int              hold_left = 0;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [DW-1:0] scale_axis(longint diff, longint unsigned m,
                                               longint unsigned d);
    longint unsigned a, mag;
    longint          val;
    if (d == 0) return '0;
    a = diff < 0 ? longint'(-diff) : longint'(diff);
    mag = (m * a) / d;
    if (mag > 64'd16777215) mag = 64'd16777215;
    val = diff < 0 ? -longint'(mag) : longint'(mag);
    return val[DW-1:0];
  endfunction

  function automatic impulse_t blast_impulse(logic [CW-1:0] bx, logic [CW-1:0] by,
                                             logic [CW-1:0] bz);
    longint          dx, dy, dz;
    longint unsigned ax, ay, az, sq, d, m;
    impulse_t        r;
    dx = longint'($signed(bx)) - cen_x;
    dy = longint'($signed(by)) - cen_y;
    dz = longint'($signed(bz)) - cen_z;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    sq = ax * ax + ay * ay + az * az;
    r = '0;
    if (sq > fmax * fmax) return r;
    d = int_root(sq);
    m = strength;
    if (sq > fmin * fmin) m = (m * (fmax - d)) / (fmax - fmin);
    r.in_range = 1'b1;
    r.px = scale_axis(dx, m, d);
    r.py = scale_axis(dy, m, d);
    r.pz = scale_axis(dz, m, d);
    return r;
  endfunction

  task automatic send_body(logic [CW-1:0] bx, logic [CW-1:0] by, logic [CW-1:0] bz,
                           bit typed, impulse_t want);
    bit acc;
    impulse_t e;
    in_valid <= 1'b1;
    in_body_x <= bx;
    in_body_y <= by;
    in_body_z <= bz;
    e = typed ? want : blast_impulse(bx, by, bz);
    do begin
      @(negedge clk);
      acc = in_ready;
      if (acc) pending_impulses.push_back(e);
      @(posedge clk);
    end while (!acc);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_impulses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CW-1:0] v);
    bit acc;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    case (idx)
      CFG_STRENGTH: strength = 64'(v);
      CFG_MIN:      fmin = 64'(v);
      CFG_MAX:      fmax = 64'(v);
      CFG_CX:       cen_x = longint'($signed(v));
      CFG_CY:       cen_y = longint'($signed(v));
      CFG_CZ:       cen_z = longint'($signed(v));
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle;
    end
  end

  always @(negedge clk) begin
    impulse_t got, e;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_in_range, out_push_x, out_push_y, out_push_z};
      if (pending_impulses.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: %p", got);
      end else begin
        e = pending_impulses.pop_front();
        if (got !== e) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", e, got);
        end
      end
    end
  end

  function automatic logic [CW-1:0] near(longint c, longint unsigned rad);
    longint unsigned span;
    longint off, v;
    span = rad + rad / 4 + 4;
    if (span > 64'd16000000) span = 64'd16000000;
    off = longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span);
    v = c + off;
    return v[CW-1:0];
  endfunction

  localparam impulse_t ZERO_IMP = '0;
  localparam impulse_t ORIGIN_IMP = '{1'b1, 25'd0, 25'd0, 25'd0};

  row_t rows[] = '{
    '{24'd0, 24'd0, 24'd0, 1'b1, ORIGIN_IMP},
    '{24'd256, 24'd0, 24'd0, 1'b1, '{1'b1, 25'd1280000, 25'd0, 25'd0}},
    '{24'd0, -24'sd256, 24'd0, 1'b1, '{1'b1, 25'd0, -25'sd1280000, 25'd0}},
    '{24'd0, 24'd0, 24'd25600, 1'b1, ORIGIN_IMP},
    '{24'd25601, 24'd0, 24'd0, 1'b1, ZERO_IMP},
    '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, ZERO_IMP},
    '{24'h800000, 24'h800000, 24'h800000, 1'b1, ZERO_IMP},
    '{24'h7FFFFF, 24'd0, 24'd0, 1'b1, ZERO_IMP},
    '{24'h800000, 24'd0, 24'd0, 1'b1, ZERO_IMP},
    '{24'd2560, 24'd0, 24'd0, 1'b0, ZERO_IMP},
    '{24'd2561, 24'd0, 24'd0, 1'b0, ZERO_IMP},
    '{24'd1000, -24'sd1000, 24'd1000, 1'b0, ZERO_IMP},
    '{-24'sd5000, 24'd7000, -24'sd9000, 1'b0, ZERO_IMP},
    '{24'd14780, 24'd14780, 24'd14780, 1'b0, ZERO_IMP},
    '{24'd1, 24'd1, 24'd1, 1'b0, ZERO_IMP},
    '{-24'sd1, 24'd0, 24'd0, 1'b0, ZERO_IMP},
    '{24'd12800, -24'sd12800, 24'd0, 1'b0, ZERO_IMP},
    '{24'd0, 24'd0, -24'sd20000, 1'b0, ZERO_IMP}
  };

  initial begin
    logic [CW-1:0] s, lo, hi, cx, cy, cz;
    strength = 1280000;
    fmin = 2560;
    fmax = 25600;
    cen_x = 0;
    cen_y = 0;
    cen_z = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_body(rows[i].bx, rows[i].by, rows[i].bz, rows[i].typed,
                                rows[i].want);
    for (int p = 0; p < 9; p++) begin
      drain();
      s = CW'($urandom);
      lo = CW'($urandom_range(0, 40000));
      hi = lo + CW'($urandom_range(1, 200000));
      cx = CW'($urandom);
      cy = CW'($urandom);
      cz = CW'($urandom);
      case (p)
        1: begin
          s = 24'hFFFFFF; lo = 24'd0; hi = 24'hFFFFFF;
          cx = 24'h800000; cy = 24'h7FFFFF; cz = 24'd0;
        end
        2: begin
          lo = 24'd50000; hi = 24'd30000;
        end
        3: begin
          s = 24'd0; lo = 24'd0; hi = 24'd1;
          cx = 24'h7FFFFF; cy = 24'h800000; cz = 24'h7FFFFF;
        end
        5: begin
          lo = 24'hFFFFFF; hi = 24'hFFFFFF; s = 24'hFFFFFF;
        end
        6: begin
          lo = 24'd0; hi = 24'd0;
        end
        default: ;
      endcase
      write_reg(CFG_STRENGTH, s);
      write_reg(CFG_MIN, lo);
      write_reg(CFG_MAX, hi);
      write_reg(CFG_CX, cx);
      write_reg(CFG_CY, cy);
      write_reg(CFG_CZ, cz);
      cfg_valid <= 1'b0;
      @(posedge clk);
      send_idle = p < 3 ? 21 : p < 6 ? 57 : 0;
      recv_idle = p < 3 ? 57 : p < 6 ? 21 : 0;
      if (p == 4) hold_req = 1'b1;
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(99) < 80)
          send_body(near(cen_x, fmax), near(cen_y, fmax), near(cen_z, fmax), 1'b0,
                    ZERO_IMP);
        else
          send_body(CW'($urandom), CW'($urandom), CW'($urandom), 1'b0, ZERO_IMP);
      end
    end
    in_valid <= 1'b0;
    while (pending_impulses.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("** radial_impulse_falloff: PASSED **");
    else
      $display("** radial_impulse_falloff: FAILED **");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/rif_pkg.sv
hw/rtl/rif_sqrt_cell.sv
hw/rtl/rif_div_cell.sv
hw/rtl/radial_impulse_falloff.sv
hw/rtl/rif_checker.sv
tb/tb_top.sv
